>>> sv/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

  // Bitmap is held in 32-bit words
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  localparam logic [1:0] OP_ALLOCATE = 2'd0;
  localparam logic [1:0] OP_REQUEST  = 2'd1;
  localparam logic [1:0] OP_RELEASE  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] blk_idx;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] granted_block;
    logic [8:0] used_count;
    logic [8:0] free_count;
  } res_t;

  // find-first-zero result
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } ffz_res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_t;

endpackage

>>> sv/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// Request/release pass ST_READ and ST_SCAN before done; allocate scans k words (1 ..
//   ceil(NUM_BLOCKS/32), 8 at 256 blocks), one 32-bit word per cycle, through the single
//   find-first-zero unit. Bad op, block-zero request, out-of-range id: done next cycle.
// Throughput: one command at a time; start is taken again in the cycle done is shown.
// Reset: a clearing pass writes every bitmap word to zero, with busy high. The result
//   receiver cannot stall; done is a one-cycle strobe.

module bitmap_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bba_pkg::cmd_t cmd,
  output logic          done,
  output bba_pkg::res_t result
);

  import bba_pkg::*;

  // bitmap geometry
  localparam int unsigned NW     = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W   = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned TAIL   = NUM_BLOCKS % WORD_W;
  // bits past the last block in the top word must never be handed out
  localparam logic [WORD_W-1:0] TAIL_MASK =
    (TAIL == 0) ? '0 : ~((WORD_W'(1) << TAIL) - WORD_W'(1));
  localparam logic [WA_W-1:0]   LAST_WORD = WA_W'(NW - 1);

  state_t            state, state_next;
  logic [WA_W-1:0]   word_addr, word_addr_next;
  logic [CNT_W-1:0]  used_total, used_next;
  logic              done_next;
  res_t              result_next;
  cmd_t              cmd_q;

  // RAM port signals
  logic              ram_we;
  logic [WA_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // scan datapath
  logic [WORD_W-1:0] scan_word;
  ffz_res_t          ffz;
  logic              id_bit;
  logic [31:0]       id_word;
  logic              id_in_range;
  logic [31:0]       grant_full;
  logic [31:0]       used_wide, free_wide;
  logic [CNT_W-1:0]  free_next;

  logic              emit;
  logic              emit_ok;
  logic [7:0]        emit_grant;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // top word gets its unused tail forced to "in use" before the search
  assign scan_word = ram_rdata | ((word_addr == LAST_WORD) ? TAIL_MASK : '0);

  bba_ffz u_ffz (
    .word (scan_word),
    .res  (ffz)
  );

  assign id_bit      = ram_rdata[cmd_q.blk_idx[BIT_W-1:0]];
  assign id_word     = 32'(cmd.blk_idx) >> BIT_W;
  assign id_in_range = 32'(cmd.blk_idx) < NUM_BLOCKS;
  assign grant_full  = 32'({word_addr, ffz.idx});

  assign busy = (state != ST_IDLE);

  // counts reported after the operation, truncated to field width
  assign free_next = CNT_W'(NUM_BLOCKS) - used_next;
  assign used_wide = 32'(used_next);
  assign free_wide = 32'(free_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      word_addr  <= '0;
      used_total <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      word_addr  <= word_addr_next;
      used_total <= used_next;
      done       <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= result_next;
    if (start && !busy) begin
      cmd_q <= cmd;
    end
  end

  always_comb begin
    state_next     = state;
    word_addr_next = word_addr;
    used_next      = used_total;
    ram_we         = 1'b0;
    ram_waddr      = word_addr;
    ram_wdata      = ram_rdata;
    ram_raddr      = word_addr;
    emit           = 1'b0;
    emit_ok        = 1'b0;
    emit_grant     = '0;

    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (word_addr == LAST_WORD) begin
          state_next     = ST_IDLE;
          word_addr_next = '0;
        end else begin
          word_addr_next = word_addr + WA_W'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          case (cmd.op)
            OP_ALLOCATE: begin
              word_addr_next = '0;
              state_next     = ST_READ;
            end
            OP_REQUEST: begin
              if (cmd.blk_idx == '0 || !id_in_range) begin
                emit = 1'b1;   // refused, no map access
              end else begin
                word_addr_next = id_word[WA_W-1:0];
                state_next     = ST_READ;
              end
            end
            OP_RELEASE: begin
              if (!id_in_range) begin
                emit    = 1'b1;
                emit_ok = 1'b1;
              end else begin
                word_addr_next = id_word[WA_W-1:0];
                state_next     = ST_READ;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        ram_raddr  = word_addr;
        state_next = ST_SCAN;
      end

      ST_SCAN: begin
        // prefetch the next word so the allocate scan runs one word per cycle
        ram_raddr = (word_addr == LAST_WORD) ? word_addr : word_addr + WA_W'(1);
        case (cmd_q.op)
          OP_ALLOCATE: begin
            if (ffz.found) begin
              ram_we     = 1'b1;
              ram_wdata  = ram_rdata | (WORD_W'(1) << ffz.idx);
              used_next  = used_total + CNT_W'(1);
              emit       = 1'b1;
              emit_ok    = 1'b1;
              emit_grant = grant_full[7:0];
              state_next = ST_IDLE;
            end else if (word_addr == LAST_WORD) begin
              emit       = 1'b1;  // map full
              state_next = ST_IDLE;
            end else begin
              word_addr_next = word_addr + WA_W'(1);
            end
          end
          OP_REQUEST: begin
            if (!id_bit) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata | (WORD_W'(1) << cmd_q.blk_idx[BIT_W-1:0]);
              used_next = used_total + CNT_W'(1);
              emit_ok   = 1'b1;
            end
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
          OP_RELEASE: begin
            if (id_bit) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~(WORD_W'(1) << cmd_q.blk_idx[BIT_W-1:0]);
              used_next = used_total - CNT_W'(1);
            end
            emit       = 1'b1;
            emit_ok    = 1'b1;
            state_next = ST_IDLE;
          end
          default: begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase

    done_next                 = emit;
    result_next.ok            = emit_ok;
    result_next.granted_block = emit_grant;
    result_next.used_count    = used_wide[8:0];
    result_next.free_count    = free_wide[8:0];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // used and free always add up to the block count (mod field width)
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (9'(result.used_count + result.free_count) == 9'(NUM_BLOCKS)))
    else $error("used_count + free_count mismatch");

  // a failed transfer never grants a block
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.granted_block == '0))
    else $error("failed operation reported a granted block");

  // clearing pass holds off commands right after reset
  a_clear_busy: assert property (@(posedge clk)
    rst |=> busy)
    else $error("not busy during clearing pass");

  // used counter never passes the number of blocks
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used_total) <= NUM_BLOCKS)
    else $error("used block count overflow");

endmodule

>>> sv/bba_ram.sv
`timescale 1ns / 1ps

module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bba_ffz.sv
`timescale 1ns / 1ps

module bba_ffz (
  input  logic [31:0]       word,
  output bba_pkg::ffz_res_t res
);

  import bba_pkg::*;

  logic [3:0]       byte_has;
  logic [2:0]       byte_idx [4];

  // lowest zero bit inside each byte
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      byte_has[b] = 1'b0;
      byte_idx[b] = '0;
      for (int i = 7; i >= 0; i--) begin
        if (!word[b*8 + i]) begin
          byte_has[b] = 1'b1;
          byte_idx[b] = 3'(i);
        end
      end
    end
  end

  // lowest byte holding a zero
  always_comb begin
    res = '0;
    for (int b = 3; b >= 0; b--) begin
      if (byte_has[b]) begin
        res.found = 1'b1;
        res.idx   = {2'(b), byte_idx[b]};
      end
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import bba_pkg::*;

  localparam int unsigned NUM_BLOCKS = 256;
  // op code the block does not define; must answer ok = 0 and change nothing
  localparam logic [1:0] OP_SPARE = 2'd3;
  // settle time after the last result, well past the longest allocate scan
  localparam int TAIL_CYCLES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  res_t result;

  bitmap_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always #4 clk = ~clk;

  // Commands waiting to be driven, and the replies predicted for commands
  // already transferred (oldest first).
  cmd_t cmd_queue[$];
  res_t due_results[$];

  // Shadow of the allocator: one in-use bit per block plus the used count.
  logic [NUM_BLOCKS-1:0] shadow_map = '0;
  int unsigned shadow_used = 0;

  // Chance, in percent, that the driver leaves a cycle empty.
  int send_idle_pct = 16;
  int n_err = 0;
  int n_sent = 0;
  int n_grant = 0;
  int n_full = 0;
  int n_refused = 0;
  int n_release = 0;
  int n_spare = 0;
  res_t want;

  // Apply one command to the shadow map and return the reply it must give.
  function automatic res_t apply_cmd(cmd_t c);
    res_t r;
    int slot;
    r = '0;
    slot = -1;
    case (c.op)
      OP_ALLOCATE: begin
        // lowest free block wins, block zero included
        for (int i = 0; i < NUM_BLOCKS; i++)
          if (slot < 0 && !shadow_map[i]) slot = i;
        if (slot >= 0) begin
          shadow_map[slot] = 1'b1;
          shadow_used++;
          r.ok = 1'b1;
          r.granted_block = slot[7:0];
          n_grant++;
        end else begin
          n_full++;
        end
      end
      OP_REQUEST: begin
        // block zero, out of range, or already taken: refused
        if (c.blk_idx != 0 && c.blk_idx < NUM_BLOCKS && !shadow_map[c.blk_idx]) begin
          shadow_map[c.blk_idx] = 1'b1;
          shadow_used++;
          r.ok = 1'b1;
        end else begin
          n_refused++;
        end
      end
      OP_RELEASE: begin
        // releasing a free or out-of-range block is silently ignored
        if (c.blk_idx < NUM_BLOCKS && shadow_map[c.blk_idx]) begin
          shadow_map[c.blk_idx] = 1'b0;
          shadow_used--;
        end
        r.ok = 1'b1;
        n_release++;
      end
      default: n_spare++;
    endcase
    r.used_count = shadow_used[8:0];
    r.free_count = 9'(NUM_BLOCKS - shadow_used);
    return r;
  endfunction

  // Driver: a command transfers on an edge with start high and busy low.
  // Start is only held up against busy; otherwise each cycle the next
  // command goes out unless the idle draw leaves the cycle empty.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_results.push_back(apply_cmd(cmd));
        n_sent++;
      end
      if (start && busy) begin
        // hold the same command until the block takes it
      end else if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        start <= 1'b1;
        cmd <= cmd_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: done is a one-cycle strobe; every strobe must match the
  // oldest prediction field by field.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        $error("result with no transfer pending: ok=%0d granted=%0d used=%0d free=%0d",
               result.ok, result.granted_block, result.used_count, result.free_count);
        n_err++;
      end else begin
        want = due_results.pop_front();
        if (result.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, result.ok);
          n_err++;
        end
        if (result.granted_block !== want.granted_block) begin
          $error("granted_block: expected %0d, got %0d", want.granted_block,
                 result.granted_block);
          n_err++;
        end
        if (result.used_count !== want.used_count) begin
          $error("used_count: expected %0d, got %0d", want.used_count, result.used_count);
          n_err++;
        end
        if (result.free_count !== want.free_count) begin
          $error("free_count: expected %0d, got %0d", want.free_count, result.free_count);
          n_err++;
        end
      end
    end
  end

  task automatic push_cmd(logic [1:0] op, logic [7:0] id);
    cmd_t c;
    c.op = op;
    c.blk_idx = id;
    cmd_queue.push_back(c);
  endtask

  // Random mix of all ops; releases lean toward low ids since allocate
  // fills from the bottom, so many of them actually free something.
  task automatic queue_mix(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        push_cmd(OP_ALLOCATE, 8'($urandom_range(0, 255)));
      else if (r < 65)
        push_cmd(OP_REQUEST, ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
      else if (r < 80)
        push_cmd(OP_RELEASE, 8'($urandom_range(0, 63)));
      else if (r < 95)
        push_cmd(OP_RELEASE, 8'($urandom_range(0, 255)));
      else
        push_cmd(OP_SPARE, 8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly allocates, enough to fill the whole map and run past full;
  // the scan crosses every word boundary on the way.
  task automatic queue_fill();
    for (int k = 0; k < NUM_BLOCKS + 4; k++) begin
      if ($urandom_range(0, 7) == 0)
        push_cmd(OP_REQUEST, 8'($urandom_range(0, 255)));
      else
        push_cmd(OP_ALLOCATE, 8'($urandom_range(0, 255)));
    end
  endtask

  // Release every block once, in a random permutation (odd stride mod 256).
  task automatic queue_sweep();
    int base;
    int stride;
    base = $urandom_range(0, 255);
    stride = 2 * $urandom_range(0, 127) + 1;
    for (int k = 0; k < NUM_BLOCKS; k++)
      push_cmd(OP_RELEASE, 8'((base + k * stride) % NUM_BLOCKS));
  endtask

  // Wait until every queued command has transferred and been answered.
  task automatic drain();
    while (cmd_queue.size() != 0 || start || due_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    // Directed opening on an empty map.
    push_cmd(OP_ALLOCATE, 8'd0);     // grants block 0
    push_cmd(OP_ALLOCATE, 8'hFF);    // id ignored, grants block 1
    push_cmd(OP_REQUEST, 8'd0);      // block zero is never requestable
    push_cmd(OP_REQUEST, 8'd255);    // top block
    push_cmd(OP_REQUEST, 8'd255);    // already in use
    push_cmd(OP_REQUEST, 8'd1);      // taken by allocate
    push_cmd(OP_RELEASE, 8'd255);
    push_cmd(OP_RELEASE, 8'd255);    // already free, ignored
    push_cmd(OP_RELEASE, 8'd0);
    push_cmd(OP_ALLOCATE, 8'd0);     // block 0 again
    push_cmd(OP_REQUEST, 8'd2);
    push_cmd(OP_ALLOCATE, 8'd0);     // skips 2, grants 3
    push_cmd(OP_REQUEST, 8'd31);     // end of first word
    push_cmd(OP_REQUEST, 8'd32);     // start of second word
    push_cmd(OP_REQUEST, 8'd170);
    push_cmd(OP_REQUEST, 8'd85);
    push_cmd(OP_REQUEST, 8'd128);
    push_cmd(OP_SPARE, 8'd255);
    push_cmd(OP_SPARE, 8'd0);
    push_cmd(OP_RELEASE, 8'd1);
    push_cmd(OP_ALLOCATE, 8'd0);     // lowest free is 1 again
    push_cmd(OP_RELEASE, 8'd200);    // never used

    // Phase 1: light sender idling; fill the map and work at full.
    send_idle_pct = 16;
    queue_mix(130);
    queue_fill();
    queue_mix(40);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    drain();

    // Phase 2: heavy sender idling; empty the map, then mixed traffic.
    send_idle_pct = 85;
    queue_sweep();
    queue_mix(190);
    drain();

    // Phase 3: back-to-back commands.
    send_idle_pct = 0;
    queue_mix(180);
    queue_fill();
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d transfers: %0d grants, %0d allocates on a full map,",
             n_sent, n_grant, n_full);
    $display("  %0d refused requests, %0d releases and %0d undefined-op commands, %s",
             n_refused, n_release, n_spare, "with the map filled and emptied.");
    if (n_err == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
